### rtl/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

    // Fixed field widths
    localparam int ACC_W     = 64;  // term, sum and accumulator width
    localparam int GAIN_W    = 32;  // gain registers, signed Q8.24
    localparam int STAMP_W   = 32;  // microsecond time stamp
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TERM_MODES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd6;

    // term_modes bit positions: 1 = act on negated measurement
    localparam int MODE_P = 0;
    localparam int MODE_I = 1;
    localparam int MODE_D = 2;
    localparam logic [2:0] MODES_RESET = 3'd4;

endpackage

`default_nettype wire

### rtl/pidc_mul.sv
`default_nettype none

// Serial-parallel multiplier: the B operand streams out of a shift register
// one bit per clock, LSB first; the partial sum shifts right alongside it.
module pidc_mul
    import pidc_pkg::*;
#(
    parameter int A_W = ACC_W,
    parameter int B_W = GAIN_W
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);

    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   prod_reg;
    logic [P_W-1:0]   prod_next;
    logic [A_W:0]     sum;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             last;

    // One bit of B per clock: add A when the low bit is set, then shift
    always_comb
    begin
        sum       = {1'b0, prod_reg[P_W-1:B_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        prod_next = {sum, prod_reg[B_W-1:1]};
    end

    assign last = (cnt_reg == CNT_W'(B_W - 1));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Operand and product shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

`ifndef SYNTHESIS
    // a new product is never requested on top of a running one
    a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier restarted while busy");
`endif

endmodule

`default_nettype wire

### rtl/pidc_div.sv
`default_nettype none

// Restoring divider: one numerator bit shifts in and one quotient bit
// shifts out per clock, MSB first.
module pidc_div
    import pidc_pkg::*;
#(
    parameter int N_W = 64,
    parameter int D_W = STAMP_W
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quo
);

    localparam int CNT_W = $clog2(N_W);

    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   rem_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             last;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[N_W-1]};
        ge    = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    assign last = (cnt_reg == CNT_W'(N_W - 1));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and numerator/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef SYNTHESIS
    // partial remainder always stays below the divisor while running
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !$past(start) |-> rem_reg < den_reg)
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

### rtl/pid_controller_onx_modes.sv
// A request runs through the shared bit-serial multiplier (up to five products) and the restoring
// divider (up to two quotients); the first sample after reset updates no term.
// Throughput: one request in flight; the next is taken only after the result is registered.
// Reset: rst_n clears asynchronously to the register reset values; no clearing pass.
`default_nettype none

module pid_controller_onx_modes
    import pidc_pkg::*;
#(
    parameter int VALUE_WIDTH      = 32,
    parameter int GAIN_FRAC_BITS   = 24,
    parameter int TICKS_PER_SECOND = 1000000
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [STAMP_W-1:0]            stamp_us,
    input  logic signed [VALUE_WIDTH-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] drive,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [((VALUE_WIDTH > GAIN_W) ? VALUE_WIDTH : GAIN_W)-1:0] cfg_data
);

    localparam int VW     = VALUE_WIDTH;
    localparam int E_W    = VW + 1;          // error, negated sample
    localparam int DL_W   = VW + 2;          // derivative delta
    localparam int PROD_W = ACC_W + GAIN_W;
    localparam int NUM_W  = VW + STAMP_W;    // dividend width
    localparam int QX_W   = (NUM_W > ACC_W) ? NUM_W : ACC_W;
    localparam logic [STAMP_W-1:0] TPS_VAL = STAMP_W'(TICKS_PER_SECOND);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Term index for the gain phase
    localparam logic [1:0] TERM_P   = 2'd0;
    localparam logic [1:0] TERM_I   = 2'd1;
    localparam logic [1:0] TERM_D   = 2'd2;
    localparam logic [1:0] TERM_END = 2'd3;

    // State codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPD   = 4'd1;
    localparam logic [3:0] S_I_GO  = 4'd2;
    localparam logic [3:0] S_I_MUL = 4'd3;
    localparam logic [3:0] S_I_DIV = 4'd4;
    localparam logic [3:0] S_I_ACC = 4'd5;
    localparam logic [3:0] S_D_GO  = 4'd6;
    localparam logic [3:0] S_D_MUL = 4'd7;
    localparam logic [3:0] S_D_DIV = 4'd8;
    localparam logic [3:0] S_G_SEL = 4'd9;
    localparam logic [3:0] S_G_MUL = 4'd10;
    localparam logic [3:0] S_G_ACC = 4'd11;
    localparam logic [3:0] S_CLAMP = 4'd12;

    // Clamp a wide magnitude to the signed accumulator range and apply the sign
    function automatic logic [ACC_W-1:0] sign_cap(input logic over,
                                                  input logic [ACC_W-2:0] low,
                                                  input logic neg);
        logic [ACC_W-1:0] m;
        m = over ? ACC_MIN : {1'b0, low};
        if (neg)
            sign_cap = ACC_W'(0) - m;
        else if (over)
            sign_cap = ACC_MAX;
        else
            sign_cap = m;
    endfunction

    // Saturating signed add
    function automatic logic [ACC_W-1:0] add_sat(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            add_sat = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        else
            add_sat = s;
    endfunction

    // Configuration
    logic [2:0]               modes_reg;
    logic [GAIN_W-1:0]        gain_p_reg;
    logic [GAIN_W-1:0]        gain_i_reg;
    logic [GAIN_W-1:0]        gain_d_reg;
    logic [VW-1:0]            lim_lo_reg;
    logic [VW-1:0]            lim_hi_reg;
    logic [VW-1:0]            target_reg;

    // Controller history
    logic                     first_reg;
    logic [STAMP_W-1:0]       last_stamp_reg;
    logic [E_W-1:0]           last_err_reg;
    logic [VW-1:0]            last_samp_reg;
    logic [ACC_W-1:0]         integ_reg;
    logic [E_W-1:0]           prop_reg;
    logic [ACC_W-1:0]         deriv_reg;

    // Per-request working registers
    logic [3:0]               state_reg;
    logic [1:0]               idx_reg;
    logic [STAMP_W-1:0]       stamp_reg;
    logic [VW-1:0]            samp_reg;
    logic [STAMP_W-1:0]       dt_reg;
    logic [E_W-1:0]           err_reg;
    logic [E_W-1:0]           nsamp_reg;
    logic [DL_W-1:0]          delta_reg;
    logic [ACC_W-1:0]         step_reg;
    logic [ACC_W-1:0]         unlim_reg;

    // Output register
    logic                     out_valid_reg;
    logic [VW-1:0]            drive_reg;
    logic                     sat_reg;

    // Arithmetic unit hookup
    logic                     mul_start;
    logic [ACC_W-1:0]         mul_a;
    logic [GAIN_W-1:0]        mul_b;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_prod;
    logic                     div_start;
    logic [STAMP_W-1:0]       div_den;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quo;

    // Combinational helpers
    logic [STAMP_W-1:0]       dt_raw;
    logic [STAMP_W-1:0]       dt_val;
    logic [E_W-1:0]           s_ext;
    logic [E_W-1:0]           err_val;
    logic [E_W-1:0]           v_i;
    logic [E_W-1:0]           v_i_mag;
    logic [DL_W-1:0]          delta_val;
    logic [DL_W-1:0]          delta_mag;
    logic [ACC_W-1:0]         term_sel;
    logic [GAIN_W-1:0]        gain_sel;
    logic [ACC_W-1:0]         term_mag;
    logic [GAIN_W-1:0]        gain_mag;
    logic [QX_W-1:0]          quo_x;
    logic [ACC_W-1:0]         quo_capped;
    logic [PROD_W-1:0]        prod_sh;
    logic [ACC_W-1:0]         gterm;
    logic [ACC_W-1:0]         lo_ext;
    logic [ACC_W-1:0]         hi_ext;
    logic                     below;
    logic                     above;
    logic                     out_free;
    logic                     in_fire;
    logic                     cfg_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Time step, error and negated sample at the request
    always_comb
    begin
        dt_raw  = stamp_us - last_stamp_reg;
        dt_val  = (dt_raw == '0) ? STAMP_W'(1) : dt_raw;
        s_ext   = {sample[VW-1], sample};
        err_val = {target_reg[VW-1], target_reg} - s_ext;
    end

    // Integral input, derivative delta and their magnitudes
    always_comb
    begin
        v_i     = modes_reg[MODE_I] ? nsamp_reg : err_reg;
        v_i_mag = v_i[E_W-1] ? (E_W'(0) - v_i) : v_i;
        if (modes_reg[MODE_D])
            delta_val = {{2{last_samp_reg[VW-1]}}, last_samp_reg}
                      - {{2{samp_reg[VW-1]}}, samp_reg};
        else
            delta_val = {err_reg[E_W-1], err_reg} - {last_err_reg[E_W-1], last_err_reg};
        delta_mag = delta_reg[DL_W-1] ? (DL_W'(0) - delta_reg) : delta_reg;
    end

    // Term and gain for the gain phase
    always_comb
    begin
        case (idx_reg)
            TERM_P:
            begin
                term_sel = {{(ACC_W-E_W){prop_reg[E_W-1]}}, prop_reg};
                gain_sel = gain_p_reg;
            end
            TERM_I:
            begin
                term_sel = integ_reg;
                gain_sel = gain_i_reg;
            end
            default:
            begin
                term_sel = deriv_reg;
                gain_sel = gain_d_reg;
            end
        endcase
        term_mag = term_sel[ACC_W-1] ? (ACC_W'(0) - term_sel) : term_sel;
        gain_mag = gain_sel[GAIN_W-1] ? (GAIN_W'(0) - gain_sel) : gain_sel;
    end

    // Quotient and gained product, limited to the accumulator range
    always_comb
    begin
        quo_x      = QX_W'(div_quo);
        quo_capped = sign_cap(|quo_x[QX_W-1:ACC_W-1], quo_x[ACC_W-2:0],
                              (state_reg == S_D_DIV) ? delta_reg[DL_W-1] : v_i[E_W-1]);
        prod_sh    = mul_prod >> GAIN_FRAC_BITS;
        gterm      = sign_cap(|prod_sh[PROD_W-1:ACC_W-1], prod_sh[ACC_W-2:0],
                              term_sel[ACC_W-1] ^ gain_sel[GAIN_W-1]);
    end

    // Output limits, lower first
    always_comb
    begin
        lo_ext = {{(ACC_W-VW){lim_lo_reg[VW-1]}}, lim_lo_reg};
        hi_ext = {{(ACC_W-VW){lim_hi_reg[VW-1]}}, lim_hi_reg};
        below  = ($signed(unlim_reg) < $signed(lo_ext));
        above  = ($signed(unlim_reg) > $signed(hi_ext));
    end

    // Operand selection for the shared units
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_I_GO:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(v_i_mag);
                mul_b     = GAIN_W'(dt_reg);
            end
            S_D_GO:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(delta_mag);
                mul_b     = GAIN_W'(TPS_VAL);
            end
            S_G_SEL:
            begin
                mul_start = (idx_reg != TERM_END) && (gain_sel != '0);
                mul_a     = term_mag;
                mul_b     = gain_mag;
            end
            default:
            begin
            end
        endcase
        div_start = mul_done && (state_reg == S_I_MUL || state_reg == S_D_MUL);
        div_den   = (state_reg == S_D_MUL) ? dt_reg : TPS_VAL;
    end

    pidc_mul #(
        .A_W (ACC_W),
        .B_W (GAIN_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pidc_div #(
        .N_W (NUM_W),
        .D_W (STAMP_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod[NUM_W-1:0]),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg  <= MODES_RESET;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            lim_lo_reg <= '0;
            lim_hi_reg <= '0;
            target_reg <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_TERM_MODES: modes_reg  <= cfg_data[2:0];
                REG_GAIN_PROP:  gain_p_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEG: gain_i_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV: gain_d_reg <= cfg_data[GAIN_W-1:0];
                REG_LIMIT_LOW:  lim_lo_reg <= cfg_data[VW-1:0];
                REG_LIMIT_HIGH: lim_hi_reg <= cfg_data[VW-1:0];
                REG_TARGET:     target_reg <= cfg_data[VW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= TERM_P;
            first_reg      <= 1'b1;
            last_stamp_reg <= '0;
            last_err_reg   <= '0;
            last_samp_reg  <= '0;
            integ_reg      <= '0;
            prop_reg       <= '0;
            deriv_reg      <= '0;
            unlim_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // result register: load a new result, else drop an accepted one
            if (state_reg == S_CLAMP && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg   <= TERM_P;
                    unlim_reg <= '0;
                    if (in_fire)
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        state_reg <= S_G_SEL;
                    end
                    else
                    begin
                        if (gain_p_reg != '0)
                            prop_reg <= modes_reg[MODE_P] ? nsamp_reg : err_reg;
                        if (gain_i_reg != '0)
                            state_reg <= S_I_GO;
                        else if (gain_d_reg != '0)
                            state_reg <= S_D_GO;
                        else
                            state_reg <= S_G_SEL;
                    end
                end
                S_I_GO:
                    state_reg <= S_I_MUL;
                S_I_MUL:
                    if (mul_done)
                        state_reg <= S_I_DIV;
                S_I_DIV:
                    if (div_done)
                        state_reg <= S_I_ACC;
                S_I_ACC:
                begin
                    integ_reg <= add_sat(integ_reg, step_reg);
                    state_reg <= (gain_d_reg != '0) ? S_D_GO : S_G_SEL;
                end
                S_D_GO:
                    state_reg <= S_D_MUL;
                S_D_MUL:
                    if (mul_done)
                        state_reg <= S_D_DIV;
                S_D_DIV:
                    if (div_done)
                    begin
                        deriv_reg <= quo_capped;
                        state_reg <= S_G_SEL;
                    end
                S_G_SEL:
                begin
                    if (idx_reg == TERM_END)
                        state_reg <= S_CLAMP;
                    else if (gain_sel != '0)
                        state_reg <= S_G_MUL;
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                S_G_MUL:
                    if (mul_done)
                        state_reg <= S_G_ACC;
                S_G_ACC:
                begin
                    unlim_reg <= add_sat(unlim_reg, step_reg);
                    idx_reg   <= idx_reg + 2'd1;
                    state_reg <= S_G_SEL;
                end
                S_CLAMP:
                begin
                    if (out_free)
                    begin
                        last_stamp_reg <= stamp_reg;
                        last_err_reg   <= err_reg;
                        last_samp_reg  <= samp_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stamp_reg <= stamp_us;
            samp_reg  <= sample;
            dt_reg    <= dt_val;
            err_reg   <= err_val;
            nsamp_reg <= E_W'(0) - s_ext;
        end
        if (state_reg == S_UPD)
            delta_reg <= delta_val;
        if (state_reg == S_I_DIV && div_done)
            step_reg <= quo_capped;
        else if (state_reg == S_G_MUL && mul_done)
            step_reg <= gterm;
        if (state_reg == S_CLAMP && out_free)
        begin
            drive_reg <= below ? lim_lo_reg : (above ? lim_hi_reg : unlim_reg[VW-1:0]);
            sat_reg   <= below || above;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

`ifndef SYNTHESIS
    // a finished product only lands in a state waiting for one
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_I_MUL || state_reg == S_D_MUL ||
                      state_reg == S_G_MUL))
        else $error("multiplier result with no consumer");

    // a finished quotient only lands in a state waiting for one
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_I_DIV || state_reg == S_D_DIV))
        else $error("divider result with no consumer");

    // a clamped result carries one of the limits
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_reg |-> (drive_reg == lim_lo_reg || drive_reg == lim_hi_reg))
        else $error("saturated result not at a limit");

    // history starts only from the term update step
    a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_reg) |-> $past(state_reg) == S_UPD)
        else $error("first-sample flag cleared outside update");
`endif

endmodule

`default_nettype wire
